>>> rtl/msaa_pkg.sv
// ----------------------------------------------------------------------------
// MSAA rasterizer package
// Shared constants of the multisampled triangle rasterizer.
// ----------------------------------------------------------------------------
package msaa_pkg;
  localparam logic [23:0] DepthFar = 24'hFFFFFF;
  localparam int CoordW = 16;
  localparam int DepthW = 24;
  localparam int ColorW = 24;
endpackage

>>> rtl/msaa_triangle_pixel_shader_zbuffer.sv
// ----------------------------------------------------------------------------
// MSAA triangle pixel shader with depth buffer
// Flat-shaded triangle rasterizer with 2x2 samples and a per-sample z-buffer.
// ----------------------------------------------------------------------------
// A kind 0 beat loads one triangle corner, so corner beats can follow back to
// back. A kind 1 beat with a pixel inside the screen shades one pixel: its
// four samples pass one at a time through an edge test, a serial divider that
// is skipped for samples outside the triangle, and a read-modify-write of the
// sample memories. The result sits in an output register, and the next beat
// can be accepted in the cycle after it is loaded there, so a waiting result
// stalls the block only once the next pixel is finished as well. After reset the
// block sweeps all SCREEN_WIDTH*SCREEN_HEIGHT*4 sample entries (65536
// with the defaults), one per cycle, and accepts no beat until done.
module msaa_triangle_pixel_shader_zbuffer #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [1:0]         vertex_slot_i,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  input  logic [23:0]        vertex_depth_i,
  input  logic [7:0]         color_red_i,
  input  logic [7:0]         color_green_i,
  input  logic [7:0]         color_blue_i,
  input  logic [6:0]         pixel_x_i,
  input  logic [6:0]         pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [6:0]         out_x_o,
  output logic [6:0]         out_y_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic [3:0]         covered_mask_o
);
  localparam int Samples = SCREEN_WIDTH * SCREEN_HEIGHT * 4;
  localparam int AddrW = $clog2(Samples);

  typedef enum logic [3:0] {
    StClear, StIdle, StArea, StEdge, StMul, StSum, StDiv, StRead, StWrite, StOut
  } state_e;

  logic [msaa_pkg::DepthW-1:0] zmem [Samples];
  logic [msaa_pkg::ColorW-1:0] cmem [Samples];

  state_e state_q;
  logic [AddrW:0] clr_q;
  logic signed [15:0] cx_q [3];
  logic signed [15:0] cy_q [3];
  logic [23:0] cz_q [3];
  logic [23:0] color_q;
  logic [6:0] px_q, py_q;
  logic [1:0] k_q;
  logic signed [35:0] area_q;
  logic signed [35:0] e_q [3];
  logic signed [61:0] prod_q [3];
  logic [61:0] num_q, rem_q;
  logic [34:0] den_q;
  logic [6:0] cnt_q;
  logic [23:0] z_q;
  logic inside_q;
  logic [3:0] mask_q;
  logic [9:0] sr_q, sg_q, sb_q;
  logic [AddrW-1:0] addr_q;
  logic [23:0] zrd_q, crd_q;
  logic we_q;

  logic signed [17:0] sx, sy;
  logic signed [35:0] ev [3];
  logic signed [63:0] nsum;
  logic [AddrW-1:0] base;

  always_comb begin
    sx = $signed({1'b0, px_q, 4'd0}) + (k_q[1] ? 18'sd12 : 18'sd4);
    sy = $signed({1'b0, py_q, 4'd0}) + ((k_q == 2'd1 || k_q == 2'd2) ? 18'sd4 : 18'sd12);
    for (int i = 0; i < 3; i++) begin
      ev[i] = ($signed(36'(cx_q[(i+1)%3])) - 36'(cx_q[i])) * (36'(sy) - 36'(cy_q[i]))
            - ($signed(36'(cy_q[(i+1)%3])) - 36'(cy_q[i])) * (36'(sx) - 36'(cx_q[i]));
    end
    nsum = 64'(prod_q[0]) + 64'(prod_q[1]) + 64'(prod_q[2]);
    base = (AddrW'(py_q) * AddrW'(SCREEN_WIDTH) + AddrW'(px_q)) << 2;
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      zmem[clr_q[AddrW-1:0]] <= msaa_pkg::DepthFar;
      cmem[clr_q[AddrW-1:0]] <= '0;
    end else if (we_q) begin
      zmem[addr_q] <= z_q;
      cmem[addr_q] <= color_q;
    end
    zrd_q <= zmem[addr_q];
    crd_q <= cmem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      out_valid_o <= 1'b0;
      we_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cx_q[i] <= '0; cy_q[i] <= '0; cz_q[i] <= '0;
      end
      color_q <= '0;
    end else begin
      we_q <= (state_q == StWrite) && inside_q && (zrd_q > z_q);
      if (state_q == StOut) begin
        if (!out_valid_o || out_ready_i) out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AddrW+1)'(Samples - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            if (!kind_i) begin
              if (vertex_slot_i != 2'd3) begin
                cx_q[vertex_slot_i] <= vertex_x_i;
                cy_q[vertex_slot_i] <= vertex_y_i;
                cz_q[vertex_slot_i] <= vertex_depth_i;
                if (vertex_slot_i == 2'd0)
                  color_q <= {color_red_i, color_green_i, color_blue_i};
              end
            end else if (32'(pixel_x_i) < SCREEN_WIDTH && 32'(pixel_y_i) < SCREEN_HEIGHT) begin
              px_q <= pixel_x_i; py_q <= pixel_y_i;
              k_q <= '0; mask_q <= '0;
              sr_q <= '0; sg_q <= '0; sb_q <= '0;
              state_q <= StArea;
            end
          end
        end
        StArea: begin
          area_q <= ($signed(36'(cx_q[1])) - 36'(cx_q[0])) * (36'(cy_q[2]) - 36'(cy_q[0]))
                  - ($signed(36'(cy_q[1])) - 36'(cy_q[0])) * (36'(cx_q[2]) - 36'(cx_q[0]));
          state_q <= StEdge;
        end
        StEdge: begin
          for (int i = 0; i < 3; i++) e_q[i] <= ev[i];
          state_q <= StMul;
        end
        StMul: begin
          // e_q[1]=bc pairs z0, e_q[2]=ca pairs z1, e_q[0]=ab pairs z2.
          prod_q[0] <= 62'(e_q[1]) * $signed({38'd0, cz_q[0]});
          prod_q[1] <= 62'(e_q[2]) * $signed({38'd0, cz_q[1]});
          prod_q[2] <= 62'(e_q[0]) * $signed({38'd0, cz_q[2]});
          inside_q <= (area_q != 0) && ((e_q[0] > 0) == (e_q[1] > 0))
                      && ((e_q[1] > 0) == (e_q[2] > 0));
          state_q <= StSum;
        end
        StSum: begin
          logic signed [63:0] n;
          n = area_q < 0 ? -nsum : nsum;
          num_q <= n < 0 ? '0 : n[61:0];
          den_q <= area_q < 0 ? 35'(-area_q) : 35'(area_q);
          rem_q <= '0;
          cnt_q <= 7'd62;
          addr_q <= base + AddrW'(k_q);
          state_q <= inside_q ? StDiv : StRead;
        end
        StDiv: begin
          logic [62:0] r2;
          r2 = {rem_q, num_q[61]};
          if (r2 >= {28'd0, den_q}) begin
            rem_q <= 62'(r2 - {28'd0, den_q});
            num_q <= {num_q[60:0], 1'b1};
          end else begin
            rem_q <= r2[61:0];
            num_q <= {num_q[60:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 7'd1) state_q <= StRead;
        end
        StRead: begin
          z_q <= (|num_q[61:24]) ? msaa_pkg::DepthFar : num_q[23:0];
          state_q <= StWrite;
        end
        StWrite: begin
          logic [23:0] c;
          c = crd_q;
          if (inside_q) begin
            mask_q[k_q] <= 1'b1;
            if (zrd_q > z_q) begin
              c = color_q;
            end
          end
          sr_q <= sr_q + 10'(c[23:16]);
          sg_q <= sg_q + 10'(c[15:8]);
          sb_q <= sb_q + 10'(c[7:0]);
          k_q <= k_q + 1'b1;
          state_q <= (k_q == 2'd3) ? StOut : StEdge;
        end
        StOut: begin
          if (!out_valid_o || out_ready_i) begin
            out_x_o <= px_q; out_y_o <= py_q;
            out_red_o <= sr_q[9:2]; out_green_o <= sg_q[9:2]; out_blue_o <= sb_q[9:2];
            covered_mask_o <= mask_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
